### rtl/core/asc_pkg.sv
// package for the alarm snooze/confirm controller: payload structs, codes, widths
// used by alarm_snooze_confirm_controller_top; no dependencies
package asc_pkg;

	// field and register widths
	localparam int unsigned OpW       = 3;
	localparam int unsigned HourW     = 5;
	localparam int unsigned MinuteW   = 6;
	localparam int unsigned ReqW      = 6;
	localparam int unsigned MsgW      = 8;
	localparam int unsigned KindW     = 3;
	localparam int unsigned StatusW   = 3;
	localparam int unsigned CstateW   = 2;
	localparam int unsigned RoundW    = 3;
	localparam int unsigned ResendW   = 16;
	localparam int unsigned SnoozeW   = 17;
	localparam int unsigned ConfirmW  = 16;
	localparam int unsigned WindowW   = 11;
	localparam int unsigned PulseW    = 12;
	localparam int unsigned PendW     = 2;
	localparam int unsigned DayMinW   = 11;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 17;

	// default hold time of the confirmed state, in ticks
	localparam int unsigned DoneHoldMs = 10000;

	// time constants
	localparam logic [DayMinW-1:0] MinPerHour  = 11'd60;
	localparam int unsigned        MinPerDay   = 24 * 60;
	localparam logic [ReqW-1:0]    HourMax     = 6'd23;
	localparam logic [ReqW-1:0]    MinuteMax   = 6'd59;
	localparam logic [MinuteW-1:0] NoMinuteSeen = 6'd63;
	localparam logic [MsgW-1:0]    MsgDisable  = 8'hFF;

	// register reset values
	localparam logic [ResendW-1:0]  ResendDefault  = 16'd5000;
	localparam logic [SnoozeW-1:0]  ShortDefault   = 17'd60000;
	localparam logic [SnoozeW-1:0]  LongDefault    = 17'd120000;
	localparam logic [RoundW-1:0]   RoundsDefault  = 3'd3;
	localparam logic [ConfirmW-1:0] ConfirmDefault = 16'd30000;
	localparam logic [WindowW-1:0]  WindowDefault  = 11'd300;
	localparam logic [PulseW-1:0]   PulseOnDefault = 12'd600;
	localparam logic [PulseW-1:0]   PulseOffDefault = 12'd100;
	localparam logic [HourW-1:0]    AlarmHourDefault = 5'd7;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_RESEND   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LONG     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ROUNDS   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CONFIRM  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WINDOW   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_PULSE_ON = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_PULSE_OFF = 3'd7;

	// event codes
	localparam logic [OpW-1:0] OP_TICK    = 3'd0;
	localparam logic [OpW-1:0] OP_MINUTE  = 3'd1;
	localparam logic [OpW-1:0] OP_BUTTON  = 3'd2;
	localparam logic [OpW-1:0] OP_ACK     = 3'd3;
	localparam logic [OpW-1:0] OP_SET     = 3'd4;
	localparam logic [OpW-1:0] OP_DISABLE = 3'd5;
	localparam logic [OpW-1:0] OP_CANCEL  = 3'd6;
	localparam logic [OpW-1:0] OP_TEST    = 3'd7;

	// message kinds
	localparam logic [KindW-1:0] SEND_NONE    = 3'd0;
	localparam logic [KindW-1:0] SEND_START   = 3'd1;
	localparam logic [KindW-1:0] SEND_STOP    = 3'd2;
	localparam logic [KindW-1:0] SEND_SET     = 3'd3;
	localparam logic [KindW-1:0] SEND_DISABLE = 3'd4;

	// request status codes
	localparam logic [StatusW-1:0] ST_APPLIED = 3'd0;
	localparam logic [StatusW-1:0] ST_AWAIT   = 3'd1;
	localparam logic [StatusW-1:0] ST_LOCKED  = 3'd2;
	localparam logic [StatusW-1:0] ST_RINGING = 3'd3;
	localparam logic [StatusW-1:0] ST_BUSY    = 3'd4;
	localparam logic [StatusW-1:0] ST_INVALID = 3'd5;
	localparam logic [StatusW-1:0] ST_NONE    = 3'd6;

	// confirmation states
	localparam logic [CstateW-1:0] CS_NONE    = 2'd0;
	localparam logic [CstateW-1:0] CS_WAIT    = 2'd1;
	localparam logic [CstateW-1:0] CS_HELD    = 2'd2;

	// pending request kinds
	localparam logic [PendW-1:0] PEND_NONE    = 2'd0;
	localparam logic [PendW-1:0] PEND_SET     = 2'd1;
	localparam logic [PendW-1:0] PEND_DISABLE = 2'd2;

	// one input event
	typedef struct packed {
		logic [OpW-1:0]     operation;
		logic               clock_valid;
		logic [HourW-1:0]   clock_hour;
		logic [MinuteW-1:0] clock_minute;
		logic [ReqW-1:0]    req_hour;
		logic [ReqW-1:0]    req_minute;
	} evt_t;

	// one result
	typedef struct packed {
		logic [KindW-1:0]   send_kind;
		logic [MsgW-1:0]    msg_hour;
		logic [MsgW-1:0]    msg_minute;
		logic [MsgW-1:0]    message_id;
		logic               buzzer_on;
		logic               ringing;
		logic               snoozing;
		logic               locked;
		logic [StatusW-1:0] request_status;
		logic [CstateW-1:0] confirm_state;
		logic [RoundW-1:0]  snooze_round;
	} res_t;

endpackage

### rtl/core/alarm_snooze_confirm_controller_top.sv
// alarm snooze/confirm controller top level: event register, state update, result register
// depends on asc_pkg
//
// Every event (tick, minute update, button, ack, set/disable request, cancel, test)
// produces exactly one result. One event is taken per clock cycle unless the result
// port stalls; an event waits in the input register, where the whole state update and
// result are worked out by short logic, and is registered into the result register once
// that register is free or being taken. The result register lets the next event
// enter while a result waits to be taken. Configuration writes take effect at once and
// are meant to happen only while no event is in flight.
module alarm_snooze_confirm_controller_top #(
	parameter int unsigned DONE_HOLD_MS = asc_pkg::DoneHoldMs
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [asc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [asc_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          evt_valid,
	output logic                          evt_ready,
	input  asc_pkg::evt_t                 evt,
	output logic                          res_valid,
	input  logic                          res_ready,
	output asc_pkg::res_t                 res
);
	import asc_pkg::*;

	localparam int unsigned DoneW = $clog2(DONE_HOLD_MS + 1);
	localparam logic [DoneW-1:0] DoneLimit = DoneW'(DONE_HOLD_MS);

	// configuration registers
	logic [ResendW-1:0]  resend_ivl_q;
	logic [SnoozeW-1:0]  snooze_short_q;
	logic [SnoozeW-1:0]  snooze_long_q;
	logic [RoundW-1:0]   max_rounds_q;
	logic [ConfirmW-1:0] confirm_tmo_q;
	logic [WindowW-1:0]  window_q;
	logic [PulseW-1:0]   pulse_on_q;
	logic [PulseW-1:0]   pulse_off_q;

	// controller state
	logic [HourW-1:0]    ahour_q, ahour_d;
	logic [MinuteW-1:0]  amin_q, amin_d;
	logic                en_q, en_d;
	logic                ring_q, ring_d;
	logic                ack_q, ack_d;
	logic [ResendW-1:0]  resend_q, resend_d;
	logic                swait_q, swait_d;
	logic [SnoozeW-1:0]  selapsed_q, selapsed_d;
	logic [RoundW-1:0]   scount_q, scount_d;
	logic                buzz_q, buzz_d;
	logic                phase_q, phase_d;
	logic [PulseW-1:0]   pelapsed_q, pelapsed_d;
	logic                lock_q, lock_d;
	logic [PendW-1:0]    pkind_q, pkind_d;
	logic [HourW-1:0]    phour_q, phour_d;
	logic [MinuteW-1:0]  pmin_q, pmin_d;
	logic [ConfirmW-1:0] celapsed_q, celapsed_d;
	logic                cdone_q, cdone_d;
	logic [DoneW-1:0]    delapsed_q, delapsed_d;
	logic [MinuteW-1:0]  last_q, last_d;
	logic [MsgW-1:0]     seq_q, seq_d;

	// pipeline
	evt_t  evt_s1;
	logic  evt_valid_s1;
	logic  advance;
	res_t  res_q, res_d;
	logic  res_valid_q;

	// per-event scratch
	logic [KindW-1:0]    kind_c;
	logic [MsgW-1:0]     mhour_c, mmin_c;
	logic [StatusW-1:0]  status_c;
	logic                start_c;
	logic                fired_c;
	logic                is_set_c;
	logic [ResendW-1:0]  resend_inc;
	logic [SnoozeW-1:0]  snooze_inc, delay_c;
	logic [PulseW-1:0]   pulse_inc;
	logic [ConfirmW-1:0] confirm_inc;
	logic [DoneW-1:0]    done_inc;
	logic                last_round;
	logic [DayMinW-1:0]  now_min, alarm_min;
	logic signed [DayMinW+1:0] diff_raw, diff_adj;
	logic                need_confirm;

	// handshake
	assign advance   = evt_valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !evt_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_ivl_q   <= ResendDefault;
			snooze_short_q <= ShortDefault;
			snooze_long_q  <= LongDefault;
			max_rounds_q   <= RoundsDefault;
			confirm_tmo_q  <= ConfirmDefault;
			window_q       <= WindowDefault;
			pulse_on_q     <= PulseOnDefault;
			pulse_off_q    <= PulseOffDefault;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RESEND:    resend_ivl_q   <= cfg_data[ResendW-1:0];
				REG_SHORT:     snooze_short_q <= cfg_data[SnoozeW-1:0];
				REG_LONG:      snooze_long_q  <= cfg_data[SnoozeW-1:0];
				REG_ROUNDS:    max_rounds_q   <= cfg_data[RoundW-1:0];
				REG_CONFIRM:   confirm_tmo_q  <= cfg_data[ConfirmW-1:0];
				REG_WINDOW:    window_q       <= cfg_data[WindowW-1:0];
				REG_PULSE_ON:  pulse_on_q     <= cfg_data[PulseW-1:0];
				REG_PULSE_OFF: pulse_off_q    <= cfg_data[PulseW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
	end

	// saturating increments and limits
	assign resend_inc  = (resend_q == '1) ? resend_q : resend_q + 1'b1;
	assign snooze_inc  = (selapsed_q == '1) ? selapsed_q : selapsed_q + 1'b1;
	assign pulse_inc   = (pelapsed_q == '1) ? pelapsed_q : pelapsed_q + 1'b1;
	assign confirm_inc = (celapsed_q == '1) ? celapsed_q : celapsed_q + 1'b1;
	assign done_inc    = (delapsed_q == '1) ? delapsed_q : delapsed_q + 1'b1;
	assign last_round  = ({1'b0, scount_q} + 4'd1) >= {1'b0, max_rounds_q};
	assign delay_c     = last_round ? snooze_long_q : snooze_short_q;

	// minutes until the alarm, for the confirmation window
	assign now_min   = DayMinW'(evt_s1.clock_hour) * MinPerHour
			+ DayMinW'(evt_s1.clock_minute);
	assign alarm_min = DayMinW'(ahour_q) * MinPerHour + DayMinW'(amin_q);
	assign diff_raw  = $signed({2'b00, alarm_min}) - $signed({2'b00, now_min});
	assign diff_adj  = (diff_raw <= 0) ? diff_raw + (DayMinW+2)'(MinPerDay) : diff_raw;
	assign need_confirm = en_q && (!evt_s1.clock_valid
			|| (diff_adj <= $signed({2'b00, window_q})));
	assign is_set_c = (evt_s1.operation == OP_SET);

	// state update and result for the event in the input register
	always_comb begin
		ahour_d    = ahour_q;
		amin_d     = amin_q;
		en_d       = en_q;
		ring_d     = ring_q;
		ack_d      = ack_q;
		resend_d   = resend_q;
		swait_d    = swait_q;
		selapsed_d = selapsed_q;
		scount_d   = scount_q;
		buzz_d     = buzz_q;
		phase_d    = phase_q;
		pelapsed_d = pelapsed_q;
		lock_d     = lock_q;
		pkind_d    = pkind_q;
		phour_d    = phour_q;
		pmin_d     = pmin_q;
		celapsed_d = celapsed_q;
		cdone_d    = cdone_q;
		delapsed_d = delapsed_q;
		last_d     = last_q;
		seq_d      = seq_q;
		kind_c     = SEND_NONE;
		mhour_c    = '0;
		mmin_c     = '0;
		status_c   = ST_NONE;
		start_c    = 1'b0;
		fired_c    = 1'b0;

		case (evt_s1.operation)
			OP_TICK: begin
				// start message resend while unacknowledged
				if (ring_q && !ack_q) begin
					if (resend_inc >= resend_ivl_q) begin
						resend_d = '0;
						kind_c   = SEND_START;
						mhour_c  = MsgW'(ahour_q);
						mmin_c   = MsgW'(amin_q);
					end else begin
						resend_d = resend_inc;
					end
				end
				// snooze expiry re-rings with a pulsed buzzer
				if (swait_q && !ring_q) begin
					if (snooze_inc >= delay_c) begin
						selapsed_d = snooze_inc;
						swait_d    = 1'b0;
						scount_d   = scount_q + 1'b1;
						ring_d     = 1'b1;
						ack_d      = 1'b0;
						buzz_d     = 1'b1;
						phase_d    = 1'b0;
						pelapsed_d = '0;
						resend_d   = '0;
						kind_c     = SEND_START;
						mhour_c    = MsgW'(ahour_q);
						mmin_c     = MsgW'(amin_q);
						fired_c    = 1'b1;
					end else begin
						selapsed_d = snooze_inc;
					end
				end
				// buzzer pulse, not on the tick a snooze fires
				if (ring_q && buzz_q && !fired_c) begin
					if (!phase_q && pulse_inc >= pulse_off_q) begin
						phase_d    = 1'b1;
						pelapsed_d = '0;
					end else if (phase_q && pulse_inc >= pulse_on_q) begin
						phase_d    = 1'b0;
						pelapsed_d = '0;
					end else begin
						pelapsed_d = pulse_inc;
					end
				end
				// confirmation timeout
				if (pkind_q != PEND_NONE && !cdone_q) begin
					celapsed_d = confirm_inc;
					if (confirm_inc >= confirm_tmo_q) begin
						pkind_d = PEND_NONE;
					end
				end
				// confirmed-state hold
				if (cdone_q) begin
					if (done_inc >= DoneLimit) begin
						delapsed_d = done_inc;
						cdone_d    = 1'b0;
						pkind_d    = PEND_NONE;
					end else begin
						delapsed_d = done_inc;
					end
				end
			end
			OP_MINUTE: begin
				if (en_q && evt_s1.clock_valid && evt_s1.clock_minute != last_q) begin
					last_d = evt_s1.clock_minute;
					if (evt_s1.clock_hour == ahour_q && evt_s1.clock_minute == amin_q
							&& !ring_q) begin
						start_c = 1'b1;
					end
				end
			end
			OP_BUTTON: begin
				if (ring_q) begin
					// stop ringing, arm a snooze if rounds remain
					ring_d  = 1'b0;
					ack_d   = 1'b0;
					pkind_d = PEND_NONE;
					cdone_d = 1'b0;
					buzz_d  = 1'b0;
					phase_d = 1'b0;
					kind_c  = SEND_STOP;
					if (scount_q < max_rounds_q) begin
						swait_d    = 1'b1;
						selapsed_d = '0;
						lock_d     = 1'b1;
					end else begin
						swait_d = 1'b0;
						lock_d  = 1'b0;
					end
				end else if (pkind_q != PEND_NONE && !cdone_q) begin
					// confirm the pending request
					if (pkind_q == PEND_SET) begin
						ahour_d = phour_q;
						amin_d  = pmin_q;
						en_d    = 1'b1;
						kind_c  = SEND_SET;
						mhour_c = MsgW'(phour_q);
						mmin_c  = MsgW'(pmin_q);
					end else if (pkind_q == PEND_DISABLE) begin
						en_d    = 1'b0;
						kind_c  = SEND_DISABLE;
						mhour_c = MsgDisable;
						mmin_c  = MsgDisable;
					end
					cdone_d    = 1'b1;
					delapsed_d = '0;
				end
			end
			OP_ACK: begin
				ack_d = 1'b1;
			end
			OP_SET, OP_DISABLE: begin
				if (lock_q) begin
					status_c = ST_LOCKED;
				end else if (ring_q) begin
					status_c = ST_RINGING;
				end else if (pkind_q != PEND_NONE && !cdone_q) begin
					status_c = ST_BUSY;
				end else if (is_set_c && (evt_s1.req_hour > HourMax
						|| evt_s1.req_minute > MinuteMax)) begin
					status_c = ST_INVALID;
				end else begin
					pkind_d = is_set_c ? PEND_SET : PEND_DISABLE;
					phour_d = is_set_c ? evt_s1.req_hour[HourW-1:0] : '0;
					pmin_d  = is_set_c ? evt_s1.req_minute : '0;
					if (need_confirm) begin
						celapsed_d = '0;
						cdone_d    = 1'b0;
						status_c   = ST_AWAIT;
					end else begin
						if (is_set_c) begin
							ahour_d = evt_s1.req_hour[HourW-1:0];
							amin_d  = evt_s1.req_minute;
							en_d    = 1'b1;
							kind_c  = SEND_SET;
							mhour_c = MsgW'(evt_s1.req_hour);
							mmin_c  = MsgW'(evt_s1.req_minute);
						end else begin
							en_d    = 1'b0;
							kind_c  = SEND_DISABLE;
							mhour_c = MsgDisable;
							mmin_c  = MsgDisable;
						end
						cdone_d    = 1'b1;
						delapsed_d = '0;
						status_c   = ST_APPLIED;
					end
				end
			end
			OP_CANCEL: begin
				pkind_d = PEND_NONE;
				cdone_d = 1'b0;
			end
			default: begin
				// test alarm
				if (lock_q) begin
					status_c = ST_LOCKED;
				end else begin
					start_c = 1'b1;
				end
			end
		endcase

		// fresh alarm start
		if (start_c) begin
			ring_d   = 1'b1;
			ack_d    = 1'b0;
			swait_d  = 1'b0;
			scount_d = '0;
			buzz_d   = 1'b0;
			phase_d  = 1'b0;
			resend_d = '0;
			kind_c   = SEND_START;
			mhour_c  = MsgW'(ahour_q);
			mmin_c   = MsgW'(amin_q);
		end

		// message sequence number advances once per sent message
		if (kind_c != SEND_NONE) begin
			seq_d = seq_q + 1'b1;
		end

		res_d.send_kind      = kind_c;
		res_d.msg_hour       = mhour_c;
		res_d.msg_minute     = mmin_c;
		res_d.message_id     = (kind_c != SEND_NONE) ? seq_d : '0;
		res_d.buzzer_on      = ring_d && buzz_d && phase_d;
		res_d.ringing        = ring_d;
		res_d.snoozing       = swait_d;
		res_d.locked         = lock_d;
		res_d.request_status = status_c;
		res_d.confirm_state  = cdone_d ? CS_HELD
				: ((pkind_d != PEND_NONE) ? CS_WAIT : CS_NONE);
		res_d.snooze_round   = scount_d;
	end

	// state registers, updated once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ahour_q    <= AlarmHourDefault;
			amin_q     <= '0;
			en_q       <= 1'b1;
			ring_q     <= 1'b0;
			ack_q      <= 1'b0;
			resend_q   <= '0;
			swait_q    <= 1'b0;
			selapsed_q <= '0;
			scount_q   <= '0;
			buzz_q     <= 1'b0;
			phase_q    <= 1'b0;
			pelapsed_q <= '0;
			lock_q     <= 1'b0;
			pkind_q    <= PEND_NONE;
			phour_q    <= '0;
			pmin_q     <= '0;
			celapsed_q <= '0;
			cdone_q    <= 1'b0;
			delapsed_q <= '0;
			last_q     <= NoMinuteSeen;
			seq_q      <= '0;
		end else if (advance) begin
			ahour_q    <= ahour_d;
			amin_q     <= amin_d;
			en_q       <= en_d;
			ring_q     <= ring_d;
			ack_q      <= ack_d;
			resend_q   <= resend_d;
			swait_q    <= swait_d;
			selapsed_q <= selapsed_d;
			scount_q   <= scount_d;
			buzz_q     <= buzz_d;
			phase_q    <= phase_d;
			pelapsed_q <= pelapsed_d;
			lock_q     <= lock_d;
			pkind_q    <= pkind_d;
			phour_q    <= phour_d;
			pmin_q     <= pmin_d;
			celapsed_q <= celapsed_d;
			cdone_q    <= cdone_d;
			delapsed_q <= delapsed_d;
			last_q     <= last_d;
			seq_q      <= seq_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule
